// ===== design/camera_space_point_transform_core_defines.svh =====
// assertion macros shared by the camera-space point transform rtl
`ifndef CAMERA_SPACE_POINT_TRANSFORM_CORE_DEFINES_SVH
`define CAMERA_SPACE_POINT_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cspt_pkg.sv =====
// types and constants of the camera-space point transform
`default_nettype none

package cspt_pkg;

    localparam int CFG_IDX_BITS = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CAM_X    = 3'd0,
        CFG_CAM_Y    = 3'd1,
        CFG_CAM_Z    = 3'd2,
        CFG_PITCH_CS = 3'd3,
        CFG_YAW_CS   = 3'd4,
        CFG_ROLL_CS  = 3'd5
    } t_cfg_idx;

    // control that travels beside each pipeline stage
    typedef struct packed {
        logic vld;
        logic ovf;
        logic last;
    } t_ctl;

endpackage

`default_nettype wire

// ===== design/camera_space_point_transform_core.sv =====
// camera-space point transform: translate then rotate about x, y and z
//
// channels
//   slave stream  : one light position per beat, tdata holds x, y, z from the low
//                   bits up, tlast marks the final light of the list
//   master stream : camera-space position per beat, tdata holds x, y, z from the low
//                   bits up, tuser = overflow, tlast copies the input tlast of the beat
//   config write  : index 0..5 selects camera x/y/z, pitch, yaw, roll cos/sin words,
//                   cos in the upper half, sin in the lower half; always ready,
//                   other indexes are dropped; write only while the pipe is empty
// timing
//   seven register stages: subtract, then multiply and sum for each of the three
//   rotations; an accepted beat moves through the stages in order and o_m_tvalid
//   comes from the valid bit of the last stage
//   one beat per cycle unless the output stalls, set by the single global stage enable
// reset
//   clears all stage valid bits, camera position to zero, rotations to cos 1 sin 0
// stall
//   when the output holds a beat and i_m_tready is low the whole pipe freezes and
//   o_s_tready drops in the same cycle; nothing is lost or repeated
`default_nettype none
`include "camera_space_point_transform_core_defines.svh"

module camera_space_point_transform_core
    import cspt_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int TRIG_BITS  = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // fields from bit 0 up: point_x, point_y, point_z, zero fill
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    input  wire logic                            i_s_tlast,
    // master stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // fields from bit 0 up: view_x, view_y, view_z, zero fill
    output logic [((3*COORD_BITS+7)/8)*8-1:0]    o_m_tdata,
    // fields from bit 0 up: overflow
    output logic                                 o_m_tuser,
    output logic                                 o_m_tlast,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]         i_cfg_index,
    input  wire logic [((COORD_BITS > 2*TRIG_BITS) ? COORD_BITS : 2*TRIG_BITS)-1:0]
                                                 i_cfg_data
);

    localparam int CW     = COORD_BITS;
    localparam int TW     = TRIG_BITS;
    localparam int FRAC   = TW - 2;
    localparam int PW     = CW + TW;      // full product
    localparam int SW     = PW + 2;       // sum of two rounded products
    localparam int DW     = ((3*CW+7)/8)*8;
    localparam int NSTG   = 7;

    localparam logic signed [PW:0]   HALF = (PW+1)'(1) << (FRAC-1);
    localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] MINV = ~MAXV;
    localparam logic [2*TW-1:0]      ROT_UNIT = (2*TW)'(1) << (FRAC + TW);

    // round half up and drop the trig fraction bits
    function automatic logic signed [SW-1:0] f_rnd(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = (PW+1)'(p) + HALF;
        return SW'(t >>> FRAC);
    endfunction

    function automatic logic signed [CW-1:0] f_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        if (v > MAXV) begin
            c = MAXV;
        end else if (v < MINV) begin
            c = MINV;
        end else begin
            c = v;
        end
        return c[CW-1:0];
    endfunction

    function automatic logic f_ovr(input logic signed [SW-1:0] v);
        return (v > MAXV) || (v < MINV);
    endfunction

    // configuration registers
    logic signed [CW-1:0] r_cam_x, r_cam_y, r_cam_z;
    logic [2*TW-1:0]      r_rot_x, r_rot_y, r_rot_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
            r_rot_x <= ROT_UNIT;
            r_rot_y <= ROT_UNIT;
            r_rot_z <= ROT_UNIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CAM_X:    r_cam_x <= i_cfg_data[CW-1:0];
                CFG_CAM_Y:    r_cam_y <= i_cfg_data[CW-1:0];
                CFG_CAM_Z:    r_cam_z <= i_cfg_data[CW-1:0];
                CFG_PITCH_CS: r_rot_x <= i_cfg_data[2*TW-1:0];
                CFG_YAW_CS:   r_rot_y <= i_cfg_data[2*TW-1:0];
                CFG_ROLL_CS:  r_rot_z <= i_cfg_data[2*TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // cos in the upper half, sin in the lower half
    logic signed [TW-1:0] w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;
    assign w_cx = r_rot_x[2*TW-1:TW];
    assign w_sx = r_rot_x[TW-1:0];
    assign w_cy = r_rot_y[2*TW-1:TW];
    assign w_sy = r_rot_y[TW-1:0];
    assign w_cz = r_rot_z[2*TW-1:TW];
    assign w_sz = r_rot_z[TW-1:0];

    // one enable for the whole pipe: move unless the output beat is stuck
    t_ctl r_ctl [NSTG];
    t_ctl n_ctl [NSTG];
    logic w_en;

    assign w_en       = !r_ctl[NSTG-1].vld || i_m_tready;
    assign o_s_tready = w_en;

    logic signed [CW-1:0] w_px, w_py, w_pz;
    assign w_px = i_s_tdata[CW-1:0];
    assign w_py = i_s_tdata[2*CW-1:CW];
    assign w_pz = i_s_tdata[3*CW-1:2*CW];

    // stage registers
    logic signed [CW-1:0] r_x1, r_y1, r_z1, n_x1, n_y1, n_z1;
    logic signed [PW-1:0] r_p2a, r_p2b, r_p2c, r_p2d, n_p2a, n_p2b, n_p2c, n_p2d;
    logic signed [CW-1:0] r_x2, n_x2;
    logic signed [CW-1:0] r_x3, r_y3, r_z3, n_x3, n_y3, n_z3;
    logic signed [PW-1:0] r_p4a, r_p4b, r_p4c, r_p4d, n_p4a, n_p4b, n_p4c, n_p4d;
    logic signed [CW-1:0] r_y4, n_y4;
    logic signed [CW-1:0] r_x5, r_y5, r_z5, n_x5, n_y5, n_z5;
    logic signed [PW-1:0] r_p6a, r_p6b, r_p6c, r_p6d, n_p6a, n_p6b, n_p6c, n_p6d;
    logic signed [CW-1:0] r_z6, n_z6;
    logic signed [CW-1:0] r_x7, r_y7, r_z7, n_x7, n_y7, n_z7;

    always_comb begin
        logic signed [SW-1:0] dx, dy, dz;
        logic signed [SW-1:0] s3y, s3z, s5x, s5z, s7x, s7y;

        // stage 1: subtract camera position, saturated
        dx = SW'(w_px) - SW'(r_cam_x);
        dy = SW'(w_py) - SW'(r_cam_y);
        dz = SW'(w_pz) - SW'(r_cam_z);
        n_x1 = f_sat(dx);
        n_y1 = f_sat(dy);
        n_z1 = f_sat(dz);
        n_ctl[0].vld  = i_s_tvalid;
        n_ctl[0].last = i_s_tlast;
        n_ctl[0].ovf  = f_ovr(dx) || f_ovr(dy) || f_ovr(dz);

        // stage 2: pitch products y*c, z*s, y*s, z*c
        n_p2a = PW'(r_y1) * PW'(w_cx);
        n_p2b = PW'(r_z1) * PW'(w_sx);
        n_p2c = PW'(r_y1) * PW'(w_sx);
        n_p2d = PW'(r_z1) * PW'(w_cx);
        n_x2  = r_x1;
        n_ctl[1] = r_ctl[0];

        // stage 3: pitch sums
        s3y = f_rnd(r_p2a) - f_rnd(r_p2b);
        s3z = f_rnd(r_p2c) + f_rnd(r_p2d);
        n_x3 = r_x2;
        n_y3 = f_sat(s3y);
        n_z3 = f_sat(s3z);
        n_ctl[2]     = r_ctl[1];
        n_ctl[2].ovf = r_ctl[1].ovf || f_ovr(s3y) || f_ovr(s3z);

        // stage 4: yaw products x*c, z*s, z*c, x*s
        n_p4a = PW'(r_x3) * PW'(w_cy);
        n_p4b = PW'(r_z3) * PW'(w_sy);
        n_p4c = PW'(r_z3) * PW'(w_cy);
        n_p4d = PW'(r_x3) * PW'(w_sy);
        n_y4  = r_y3;
        n_ctl[3] = r_ctl[2];

        // stage 5: yaw sums
        s5x = f_rnd(r_p4a) + f_rnd(r_p4b);
        s5z = f_rnd(r_p4c) - f_rnd(r_p4d);
        n_x5 = f_sat(s5x);
        n_y5 = r_y4;
        n_z5 = f_sat(s5z);
        n_ctl[4]     = r_ctl[3];
        n_ctl[4].ovf = r_ctl[3].ovf || f_ovr(s5x) || f_ovr(s5z);

        // stage 6: roll products x*c, y*s, y*c, x*s
        n_p6a = PW'(r_x5) * PW'(w_cz);
        n_p6b = PW'(r_y5) * PW'(w_sz);
        n_p6c = PW'(r_y5) * PW'(w_cz);
        n_p6d = PW'(r_x5) * PW'(w_sz);
        n_z6  = r_z5;
        n_ctl[5] = r_ctl[4];

        // stage 7: roll sums, feeds the output register
        s7x = f_rnd(r_p6a) - f_rnd(r_p6b);
        s7y = f_rnd(r_p6c) + f_rnd(r_p6d);
        n_x7 = f_sat(s7x);
        n_y7 = f_sat(s7y);
        n_z7 = r_z6;
        n_ctl[6]     = r_ctl[5];
        n_ctl[6].ovf = r_ctl[5].ovf || f_ovr(s7x) || f_ovr(s7y);
    end

    // control bits, reset clears the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (w_en) begin
            for (int k = 0; k < NSTG; k++) begin
                r_ctl[k] <= n_ctl[k];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1  <= n_x1;  r_y1  <= n_y1;  r_z1  <= n_z1;
            r_p2a <= n_p2a; r_p2b <= n_p2b; r_p2c <= n_p2c; r_p2d <= n_p2d;
            r_x2  <= n_x2;
            r_x3  <= n_x3;  r_y3  <= n_y3;  r_z3  <= n_z3;
            r_p4a <= n_p4a; r_p4b <= n_p4b; r_p4c <= n_p4c; r_p4d <= n_p4d;
            r_y4  <= n_y4;
            r_x5  <= n_x5;  r_y5  <= n_y5;  r_z5  <= n_z5;
            r_p6a <= n_p6a; r_p6b <= n_p6b; r_p6c <= n_p6c; r_p6d <= n_p6d;
            r_z6  <= n_z6;
            r_x7  <= n_x7;  r_y7  <= n_y7;  r_z7  <= n_z7;
        end
    end

    assign o_m_tvalid = r_ctl[NSTG-1].vld;
    assign o_m_tuser  = r_ctl[NSTG-1].ovf;
    assign o_m_tlast  = r_ctl[NSTG-1].last;
    assign o_m_tdata  = DW'({r_z7, r_y7, r_x7});

    // input ready only drops while the output beat is held
    `CSPT_ASSERT_NOW(a_ready_stall, i_clk, i_rst_n, !o_s_tready,
        o_m_tvalid && !i_m_tready, "input stalled without output back-pressure")

    // an accepted beat lands in the first stage with its tlast
    `CSPT_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
        r_ctl[0].vld && (r_ctl[0].last == $past(i_s_tlast)), "accepted beat lost at entry")

    // a moving beat reaches the output register
    `CSPT_ASSERT_NEXT(a_reach_out, i_clk, i_rst_n, w_en && r_ctl[NSTG-2].vld,
        o_m_tvalid, "beat dropped before the output register")

    // an overflow once flagged is never cleared on the way down
    `CSPT_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n,
        w_en && r_ctl[NSTG-2].vld && r_ctl[NSTG-2].ovf,
        o_m_tuser, "overflow flag lost in the last stage")

endmodule

`default_nettype wire

// ===== tb/tb_camera_space_point_transform_core.sv =====
// self-checking testbench for the camera-space point transform core
`default_nettype none

module tb_camera_space_point_transform_core
    import cspt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = 32;
    localparam int TRIG_W      = 16;
    localparam int DATA_W      = ((3*COORD_W+7)/8)*8;
    localparam int PIPE_DEPTH  = 7;
    localparam int MAX_WAIT    = 12;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ROUND_SHIFT = TRIG_W - 2;
    localparam longint ROUND_HALF = 64'sd1 <<< (ROUND_SHIFT - 1);
    localparam longint COORD_HI   = 64'sd2147483647;
    localparam longint COORD_LO   = -64'sd2147483648;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    // cos 1.0, sin 0
    localparam logic [2*TRIG_W-1:0] TRIG_UNIT = 32'h4000_0000;
    localparam logic [TRIG_W-1:0]   TRIG_TOP  = 16'h7fff;
    localparam logic [TRIG_W-1:0]   TRIG_BOT  = 16'h8000;
    localparam logic [TRIG_W-1:0]   TRIG_HALF = 16'h2000;
    // indexes past the register list, dropped by the block
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] vz;
        logic [COORD_W-1:0] vy;
        logic [COORD_W-1:0] vx;
        logic               ovf;
        logic               last;
    } t_view;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [DATA_W-1:0]        i_s_tdata;
    logic                     i_s_tlast;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [DATA_W-1:0]        o_m_tdata;
    logic                     o_m_tuser;
    logic                     o_m_tlast;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [COORD_W-1:0]       i_cfg_data;

    camera_space_point_transform_core #(
        .COORD_BITS(COORD_W),
        .TRIG_BITS (TRIG_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the camera registers
    logic [COORD_W-1:0]  cam_pos [3];
    logic [2*TRIG_W-1:0] rot_cs  [3];
    logic                sum_clamped;

    t_view view_q [$];

    bit tx_full;
    bit rx_full;
    int hold_req;
    int fail_count;
    int points_sent;
    int views_checked;
    int reg_writes;
    int stall_cycles;
    int cycle_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic longint clamp_coord(longint v);
        if (v > COORD_HI) begin
            sum_clamped = 1'b1;
            return COORD_HI;
        end
        if (v < COORD_LO) begin
            sum_clamped = 1'b1;
            return COORD_LO;
        end
        return v;
    endfunction

    // coord * trig back to the coordinate format, half rounds up
    function automatic longint scale_round(longint c, longint t);
        return (c * t + ROUND_HALF) >>> ROUND_SHIFT;
    endfunction

    function automatic longint trig_cos(logic [2*TRIG_W-1:0] w);
        return longint'($signed(w[2*TRIG_W-1:TRIG_W]));
    endfunction

    function automatic longint trig_sin(logic [2*TRIG_W-1:0] w);
        return longint'($signed(w[TRIG_W-1:0]));
    endfunction

    function automatic t_view view_of_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                            logic [COORD_W-1:0] pz, logic last);
        longint x, y, z, t, c, s;
        t_view  r;
        sum_clamped = 1'b0;
        // translate
        x = clamp_coord(longint'($signed(px)) - longint'($signed(cam_pos[0])));
        y = clamp_coord(longint'($signed(py)) - longint'($signed(cam_pos[1])));
        z = clamp_coord(longint'($signed(pz)) - longint'($signed(cam_pos[2])));
        // pitch, about x
        c = trig_cos(rot_cs[0]);
        s = trig_sin(rot_cs[0]);
        t = clamp_coord(scale_round(y, c) - scale_round(z, s));
        z = clamp_coord(scale_round(y, s) + scale_round(z, c));
        y = t;
        // yaw, about y
        c = trig_cos(rot_cs[1]);
        s = trig_sin(rot_cs[1]);
        t = clamp_coord(scale_round(x, c) + scale_round(z, s));
        z = clamp_coord(scale_round(z, c) - scale_round(x, s));
        x = t;
        // roll, about z
        c = trig_cos(rot_cs[2]);
        s = trig_sin(rot_cs[2]);
        t = clamp_coord(scale_round(x, c) - scale_round(y, s));
        y = clamp_coord(scale_round(y, c) + scale_round(x, s));
        x = t;
        r.vx   = x[COORD_W-1:0];
        r.vy   = y[COORD_W-1:0];
        r.vz   = z[COORD_W-1:0];
        r.ovf  = sum_clamped;
        r.last = last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------

    function automatic logic [COORD_W-1:0] draw_coord();
        logic [COORD_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 3))
            0: return v;
            1: return {{11{v[20]}}, v[20:0]};
            2: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    3: return 32'd1;
                    default: return '1;
                endcase
            end
            default: return {{4{v[27]}}, v[27:0]};
        endcase
    endfunction

    function automatic logic [2*TRIG_W-1:0] trig_word();
        real angle;
        int  c, s;
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                // a real rotation on the unit circle
                angle = $urandom_range(0, 62831) / 10000.0;
                c = int'($cos(angle) * 16384.0);
                s = int'($sin(angle) * 16384.0);
                return {c[TRIG_W-1:0], s[TRIG_W-1:0]};
            end
            3: return $urandom();
            4: return TRIG_UNIT;
            default: return {($urandom_range(0, 1) ? TRIG_TOP : TRIG_BOT),
                             ($urandom_range(0, 1) ? TRIG_TOP : TRIG_BOT)};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CAM_X:    cam_pos[0] = val;
            CFG_CAM_Y:    cam_pos[1] = val;
            CFG_CAM_Z:    cam_pos[2] = val;
            CFG_PITCH_CS: rot_cs[0]  = val;
            CFG_YAW_CS:   rot_cs[1]  = val;
            CFG_ROLL_CS:  rot_cs[2]  = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_view(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                            logic [COORD_W-1:0] cz, logic [2*TRIG_W-1:0] pitch,
                            logic [2*TRIG_W-1:0] yaw, logic [2*TRIG_W-1:0] roll);
        write_reg(CFG_CAM_X, cx);
        write_reg(CFG_CAM_Y, cy);
        write_reg(CFG_CAM_Z, cz);
        write_reg(CFG_PITCH_CS, pitch);
        write_reg(CFG_YAW_CS, yaw);
        write_reg(CFG_ROLL_CS, roll);
    endtask

    // one point beat; valid stays high into the next call when no gap is drawn
    task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [COORD_W-1:0] pz, logic last);
        int gap;
        gap = tx_full ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = {pz, py, px};
        i_s_tlast  = last;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        view_q.push_back(view_of_point(px, py, pz, last));
        points_sent++;
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (view_q.size() != 0) @(posedge i_clk);
    endtask

    // idle point for register writes
    task automatic drain_pipe();
        pause_until_drained();
        repeat (PIPE_DEPTH + 3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // output pacing, counts its own hold-off cycles
    // ------------------------------------------------------------------

    initial begin : sink_pacing
        int n;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
            end else begin
                n = rx_full ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (n > 0) begin
                i_m_tready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid && hold_req == 0);
        end
    end

    // ------------------------------------------------------------------
    // result check against the oldest expected view
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : check_views
        t_view want;
        t_view got;
        if (i_rst_n) begin
            if (i_s_tvalid && !o_s_tready) stall_cycles++;
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[3*COORD_W-1:2*COORD_W], o_m_tdata[2*COORD_W-1:COORD_W],
                       o_m_tdata[COORD_W-1:0], o_m_tuser, o_m_tlast};
                if (view_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected view beat: x %h y %h z %h ovf %b last %b",
                                 got.vx, got.vy, got.vz, got.ovf, got.last);
                    fail_count++;
                end else begin
                    want = view_q.pop_front();
                    views_checked++;
                    if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                        got.ovf !== want.ovf || got.last !== want.last) begin
                        if (fail_count < 10)
                            $display({"view mismatch: want x %h y %h z %h ovf %b last %b,",
                                      " got x %h y %h z %h ovf %b last %b"},
                                     want.vx, want.vy, want.vz, want.ovf, want.last,
                                     got.vx, got.vy, got.vz, got.ovf, got.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values give the identity transform
    task automatic test_identity_after_reset();
        send_point('0, '0, '0, 1'b0);
        send_point(COORD_MAX, COORD_MIN, '1, 1'b1);
        send_point(COORD_MIN, COORD_MAX, 32'd1, 1'b0);
        send_point(32'd1, '1, '0, 1'b1);
        send_point($urandom(), $urandom(), $urandom(), 1'b0);
        drain_pipe();
    endtask

    // clamped differences, then trig words far outside the unit circle
    task automatic test_saturation();
        set_view(COORD_MIN, COORD_MAX, '0, {TRIG_TOP, TRIG_BOT}, {TRIG_BOT, TRIG_TOP},
                 {TRIG_TOP, TRIG_TOP});
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
        send_point('0, '0, '0, 1'b0);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_point(32'd1, 32'd1, 32'd1, 1'b1);
        drain_pipe();
    endtask

    // products that land exactly on half an lsb, both signs
    task automatic test_rounding();
        set_view('0, '0, '0, {TRIG_HALF, 16'h0000}, {TRIG_HALF, TRIG_HALF}, TRIG_UNIT);
        send_point(32'd3, 32'd1, -32'sd3, 1'b0);
        send_point(-32'sd1, -32'sd3, 32'd3, 1'b1);
        send_point(32'd5, -32'sd5, 32'd1, 1'b0);
        send_point('0, 32'd1, -32'sd1, 1'b0);
        drain_pipe();
    endtask

    // writes to indexes past the register list change nothing
    task automatic test_spare_index();
        write_reg(CFG_IDX_SPARE_A, $urandom());
        write_reg(CFG_IDX_SPARE_B, $urandom());
        send_point(draw_coord(), draw_coord(), draw_coord(), 1'b0);
        send_point(draw_coord(), draw_coord(), draw_coord(), 1'b1);
        send_point(draw_coord(), draw_coord(), draw_coord(), 1'b0);
        drain_pipe();
    endtask

    // sink holds off while points keep coming, so the input stalls
    task automatic test_backpressure();
        int k;
        set_view(draw_coord(), draw_coord(), draw_coord(), trig_word(), trig_word(),
                 trig_word());
        hold_req = HOLD_CYCLES;
        tx_full  = 1'b1;
        for (k = 0; k < 40; k++)
            send_point(draw_coord(), draw_coord(), draw_coord(), $urandom_range(0, 7) == 0);
        tx_full = 1'b0;
        drain_pipe();
    endtask

    // six setups, the first two at the register extremes
    task automatic test_random_sweep();
        int phase, k;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_view(COORD_MAX, COORD_MAX, COORD_MAX, '1, '1, '1);
                1: set_view(COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0);
                default: set_view(draw_coord(), draw_coord(), draw_coord(), trig_word(),
                                  trig_word(), trig_word());
            endcase
            for (k = 0; k < 85; k++) begin
                // stretches where one side or both never idle
                if (k % 16 == 0) begin
                    tx_full = ($urandom_range(0, 3) == 0);
                    rx_full = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 59) == 0) pause_until_drained();
                send_point(draw_coord(), draw_coord(), draw_coord(),
                           $urandom_range(0, 7) == 0);
            end
            tx_full = 1'b0;
            rx_full = 1'b0;
            drain_pipe();
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial begin : run_tests
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CAM_X;
        i_cfg_data  = '0;
        cam_pos[0]  = '0;
        cam_pos[1]  = '0;
        cam_pos[2]  = '0;
        rot_cs[0]   = TRIG_UNIT;
        rot_cs[1]   = TRIG_UNIT;
        rot_cs[2]   = TRIG_UNIT;
        tx_full     = 1'b0;
        rx_full     = 1'b0;
        hold_req    = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_identity_after_reset();
        test_saturation();
        test_rounding();
        test_spare_index();
        test_backpressure();
        test_random_sweep();

        repeat (2*PIPE_DEPTH) @(posedge i_clk);
        if (view_q.size() != 0) begin
            $display("%0d expected views never arrived", view_q.size());
            fail_count++;
        end
        $display("%0d points, %0d views checked, %0d register writes, %0d stalled input cycles",
                 points_sent, views_checked, reg_writes, stall_cycles);
        $display("covered identity, clamping, half-lsb rounding, spare indexes, long hold-off");
        if (fail_count == 0) begin
            $display("tb_camera_space_point_transform_core passed");
        end else begin
            $display("tb_camera_space_point_transform_core failed");
        end
        $finish;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_camera_space_point_transform_core failed");
        $finish;
    end

endmodule

`default_nettype wire
